// ===== rtl/swsb_pkg.sv =====
// ----------------------------------------------------------------------------
// swsb_pkg: shared types and constants of the swept sphere box test
// Stage counts, time format, axis codes and the divider step.
// ----------------------------------------------------------------------------
`default_nettype none

package swsb_pkg;

    localparam int NUM_AXES     = 3;
    localparam int TIME_FRAC    = 28;
    localparam int DIV_STEPS    = TIME_FRAC + 1;
    localparam int DIV_FIRST    = 2;
    localparam int LANE_STAGES  = DIV_FIRST + DIV_STEPS + 1;
    localparam int MERGE_STAGES = 4;
    localparam int NUM_STAGES   = LANE_STAGES + MERGE_STAGES;
    localparam int FACE_TOL     = 1;

    localparam logic [2:0] REG_MIN_X = 3'd0;
    localparam logic [2:0] REG_MIN_Z = 3'd2;
    localparam logic [2:0] REG_MAX_X = 3'd3;
    localparam logic [2:0] REG_MAX_Z = 3'd5;

    localparam logic [1:0] NRM_ZERO = 2'b00;
    localparam logic [1:0] NRM_POS  = 2'b01;
    localparam logic [1:0] NRM_NEG  = 2'b11;

    localparam logic signed [30:0] T_ONE       = 31'(1) <<< TIME_FRAC;
    localparam logic [29:0]        T_MAG_CLAMP = 30'(1) << (TIME_FRAC + 1);

    typedef enum logic [1:0] {
        AXIS_X    = 2'd0,
        AXIS_Y    = 2'd1,
        AXIS_Z    = 2'd2,
        AXIS_NONE = 2'd3
    } axis_t;

    typedef struct packed {
        logic neg_lo;
        logic neg_hi;
        logic clamp_lo;
        logic clamp_hi;
        logic still;
        logic reject;
    } lane_flag_t;

    typedef struct packed {
        logic signed [31:0] p0;
        logic signed [32:0] v;
        logic signed [32:0] lo;
        logic signed [32:0] hi;
        logic signed [30:0] tmin;
        logic signed [30:0] tmax;
        logic               still;
        logic               reject;
    } lane_out_t;

    typedef struct packed {
        logic [32:0]          x;
        logic [DIV_STEPS-1:0] q;
    } div_state_t;

    function automatic div_state_t div_step(div_state_t s, logic [31:0] d);
        logic       ge;
        logic [32:0] r;
        div_state_t n;
        ge  = s.x >= {1'b0, d};
        r   = ge ? s.x - {1'b0, d} : s.x;
        n.x = {r[31:0], 1'b0};
        n.q = {s.q[DIV_STEPS-2:0], ge};
        return n;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/swsb_div.sv =====
// ----------------------------------------------------------------------------
// swsb_div: pipelined restoring divider
// One quotient bit per stage; numerator below twice the divisor.
// ----------------------------------------------------------------------------
`default_nettype none

module swsb_div (
    input  wire logic                           clk,
    input  wire logic [swsb_pkg::DIV_STEPS-1:0] en,
    input  wire logic [32:0]                    num,
    input  wire logic [31:0]                    den,
    output logic      [swsb_pkg::DIV_STEPS-1:0] quo
);

    swsb_pkg::div_state_t st_reg [swsb_pkg::DIV_STEPS];
    logic [31:0]          d_reg  [swsb_pkg::DIV_STEPS];
    swsb_pkg::div_state_t st_first;

    assign st_first = '{x: num, q: '0};

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            st_reg[0] <= swsb_pkg::div_step(st_first, den);
            d_reg[0]  <= den;
        end
    end

    for (genvar k = 1; k < swsb_pkg::DIV_STEPS; k++)
    begin : g_step
        always_ff @(posedge clk)
        begin
            if (en[k])
            begin
                st_reg[k] <= swsb_pkg::div_step(st_reg[k-1], d_reg[k-1]);
                d_reg[k]  <= d_reg[k-1];
            end
        end
    end

    assign quo = st_reg[swsb_pkg::DIV_STEPS-1].q;

endmodule

`default_nettype wire

// ===== rtl/swsb_lane.sv =====
// ----------------------------------------------------------------------------
// swsb_lane: slab test of one axis
// Grows the slab, divides both slab distances by the motion, orders times.
// ----------------------------------------------------------------------------
`default_nettype none

module swsb_lane (
    input  wire logic                             clk,
    input  wire logic [swsb_pkg::LANE_STAGES-1:0] en,
    input  wire logic signed [31:0]               p0,
    input  wire logic signed [31:0]               pe,
    input  wire logic signed [31:0]               bmin,
    input  wire logic signed [31:0]               bmax,
    input  wire logic [30:0]                      radius,
    output swsb_pkg::lane_out_t                   res
);

    localparam int LAST = swsb_pkg::LANE_STAGES - 2;

    logic signed [31:0]   p0_reg  [LAST+1];
    logic signed [32:0]   v_reg   [LAST+1];
    logic signed [32:0]   lo_reg  [LAST+1];
    logic signed [32:0]   hi_reg  [LAST+1];
    swsb_pkg::lane_flag_t flg_reg [1:LAST];
    logic [32:0]          an_lo_reg;
    logic [32:0]          an_hi_reg;
    logic [31:0]          ad_reg;
    swsb_pkg::lane_out_t  res_reg;

    logic signed [33:0]   num_lo;
    logic signed [33:0]   num_hi;
    logic [32:0]          an_lo;
    logic [32:0]          an_hi;
    logic [31:0]          ad;
    swsb_pkg::lane_flag_t flg_next;
    logic [swsb_pkg::DIV_STEPS-1:0] q_lo;
    logic [swsb_pkg::DIV_STEPS-1:0] q_hi;
    logic [29:0]          qm_lo;
    logic [29:0]          qm_hi;
    logic signed [30:0]   t1;
    logic signed [30:0]   t2;

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            p0_reg[0] <= p0;
            v_reg[0]  <= 33'(pe) - 33'(p0);
            lo_reg[0] <= 33'(bmin) - $signed({2'b00, radius});
            hi_reg[0] <= 33'(bmax) + $signed({2'b00, radius});
        end
    end

    for (genvar k = 1; k <= LAST; k++)
    begin : g_carry
        always_ff @(posedge clk)
        begin
            if (en[k])
            begin
                p0_reg[k] <= p0_reg[k-1];
                v_reg[k]  <= v_reg[k-1];
                lo_reg[k] <= lo_reg[k-1];
                hi_reg[k] <= hi_reg[k-1];
            end
        end
    end

    always_comb
    begin
        num_lo = 34'(lo_reg[0]) - 34'(p0_reg[0]);
        num_hi = 34'(hi_reg[0]) - 34'(p0_reg[0]);
        an_lo  = num_lo[33] ? 33'(-num_lo) : num_lo[32:0];
        an_hi  = num_hi[33] ? 33'(-num_hi) : num_hi[32:0];
        ad     = v_reg[0][32] ? 32'(-v_reg[0]) : v_reg[0][31:0];
        flg_next.neg_lo   = num_lo[33] ^ v_reg[0][32];
        flg_next.neg_hi   = num_hi[33] ^ v_reg[0][32];
        flg_next.clamp_lo = an_lo >= {ad, 1'b0};
        flg_next.clamp_hi = an_hi >= {ad, 1'b0};
        flg_next.still    = v_reg[0] == '0;
        flg_next.reject   = (33'(p0_reg[0]) < lo_reg[0]) || (33'(p0_reg[0]) > hi_reg[0]);
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            flg_reg[1] <= flg_next;
            an_lo_reg  <= an_lo;
            an_hi_reg  <= an_hi;
            ad_reg     <= ad;
        end
    end

    for (genvar k = 2; k <= LAST; k++)
    begin : g_flag
        always_ff @(posedge clk)
        begin
            if (en[k])
                flg_reg[k] <= flg_reg[k-1];
        end
    end

    swsb_div u_div_lo (
        .clk (clk),
        .en  (en[swsb_pkg::DIV_FIRST +: swsb_pkg::DIV_STEPS]),
        .num (an_lo_reg),
        .den (ad_reg),
        .quo (q_lo)
    );

    swsb_div u_div_hi (
        .clk (clk),
        .en  (en[swsb_pkg::DIV_FIRST +: swsb_pkg::DIV_STEPS]),
        .num (an_hi_reg),
        .den (ad_reg),
        .quo (q_hi)
    );

    always_comb
    begin
        qm_lo = flg_reg[LAST].clamp_lo ? swsb_pkg::T_MAG_CLAMP : {1'b0, q_lo};
        qm_hi = flg_reg[LAST].clamp_hi ? swsb_pkg::T_MAG_CLAMP : {1'b0, q_hi};
        t1 = flg_reg[LAST].neg_lo ? -$signed({1'b0, qm_lo}) : $signed({1'b0, qm_lo});
        t2 = flg_reg[LAST].neg_hi ? -$signed({1'b0, qm_hi}) : $signed({1'b0, qm_hi});
    end

    always_ff @(posedge clk)
    begin
        if (en[LAST+1])
        begin
            res_reg.p0     <= p0_reg[LAST];
            res_reg.v      <= v_reg[LAST];
            res_reg.lo     <= lo_reg[LAST];
            res_reg.hi     <= hi_reg[LAST];
            res_reg.tmin   <= (t1 < t2) ? t1 : t2;
            res_reg.tmax   <= (t1 < t2) ? t2 : t1;
            res_reg.still  <= flg_reg[LAST].still;
            res_reg.reject <= flg_reg[LAST].reject;
        end
    end

    assign res = res_reg;

endmodule

`default_nettype wire

// ===== rtl/swsb_merge.sv =====
// ----------------------------------------------------------------------------
// swsb_merge: combine the three lanes
// Intersects slab intervals, forms the impact point, picks the face normal.
// ----------------------------------------------------------------------------
`default_nettype none

module swsb_merge (
    input  wire logic                              clk,
    input  wire logic [swsb_pkg::MERGE_STAGES-1:0] en,
    input  wire swsb_pkg::lane_out_t               lane [swsb_pkg::NUM_AXES],
    output logic                                   hit,
    output logic signed [31:0]                     impact_x,
    output logic signed [31:0]                     impact_y,
    output logic signed [31:0]                     impact_z,
    output logic signed [1:0]                      normal_x,
    output logic signed [1:0]                      normal_y,
    output logic signed [1:0]                      normal_z
);

    localparam int NA = swsb_pkg::NUM_AXES;
    localparam logic signed [62:0] HALF  = 63'(1) <<< (swsb_pkg::TIME_FRAC - 1);
    localparam logic signed [36:0] TOL_S = 37'(swsb_pkg::FACE_TOL);

    logic                  hit_a_reg;
    logic [swsb_pkg::TIME_FRAC:0] tin_reg;
    swsb_pkg::axis_t       ax_a_reg;
    logic signed [31:0]    p0_a_reg [NA];
    logic signed [32:0]    v_a_reg  [NA];
    logic signed [32:0]    lo_a_reg [NA];
    logic signed [32:0]    hi_a_reg [NA];

    logic                  hit_b_reg;
    swsb_pkg::axis_t       ax_b_reg;
    logic signed [62:0]    prod_reg [NA];
    logic signed [31:0]    p0_b_reg [NA];
    logic signed [32:0]    lo_b_reg [NA];
    logic signed [32:0]    hi_b_reg [NA];
    logic                  vpos_b_reg [NA];

    logic                  hit_c_reg;
    swsb_pkg::axis_t       ax_c_reg;
    logic signed [35:0]    ph_reg   [NA];
    logic signed [32:0]    lo_c_reg [NA];
    logic signed [32:0]    hi_c_reg [NA];
    logic                  vpos_c_reg [NA];

    logic                  hit_reg;
    logic signed [31:0]    imp_reg [NA];
    logic [1:0]            nrm_reg [NA];

    logic signed [30:0]    t_in;
    logic signed [30:0]    t_out;
    swsb_pkg::axis_t       ax;
    logic                  ok;
    logic                  hit_next;
    logic signed [31:0]    imp_next [NA];
    logic [1:0]            nrm_next [NA];

    always_comb
    begin
        t_in  = '0;
        t_out = swsb_pkg::T_ONE;
        ax    = swsb_pkg::AXIS_NONE;
        ok    = 1'b1;
        for (int a = 0; a < NA; a++)
        begin
            if (ok)
            begin
                if (lane[a].still)
                begin
                    if (lane[a].reject)
                        ok = 1'b0;
                end
                else
                begin
                    if (lane[a].tmin > t_in)
                    begin
                        t_in = lane[a].tmin;
                        ax   = swsb_pkg::axis_t'(a);
                    end
                    if (lane[a].tmax < t_out)
                        t_out = lane[a].tmax;
                    if (t_in > t_out)
                        ok = 1'b0;
                end
            end
        end
        hit_next = ok && (t_in >= 0) && (t_in <= swsb_pkg::T_ONE);
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            hit_a_reg <= hit_next;
            tin_reg   <= t_in[swsb_pkg::TIME_FRAC:0];
            ax_a_reg  <= ax;
            for (int a = 0; a < NA; a++)
            begin
                p0_a_reg[a] <= lane[a].p0;
                v_a_reg[a]  <= lane[a].v;
                lo_a_reg[a] <= lane[a].lo;
                hi_a_reg[a] <= lane[a].hi;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            hit_b_reg <= hit_a_reg;
            ax_b_reg  <= ax_a_reg;
            for (int a = 0; a < NA; a++)
            begin
                prod_reg[a]   <= 63'(v_a_reg[a]) * 63'($signed({1'b0, tin_reg}));
                p0_b_reg[a]   <= p0_a_reg[a];
                lo_b_reg[a]   <= lo_a_reg[a];
                hi_b_reg[a]   <= hi_a_reg[a];
                vpos_b_reg[a] <= !v_a_reg[a][32];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            hit_c_reg <= hit_b_reg;
            ax_c_reg  <= ax_b_reg;
            for (int a = 0; a < NA; a++)
            begin
                ph_reg[a]     <= 36'(p0_b_reg[a])
                               + 36'((prod_reg[a] + HALF) >>> swsb_pkg::TIME_FRAC);
                lo_c_reg[a]   <= lo_b_reg[a];
                hi_c_reg[a]   <= hi_b_reg[a];
                vpos_c_reg[a] <= vpos_b_reg[a];
            end
        end
    end

    always_comb
    begin
        logic signed [36:0] dlo;
        logic signed [36:0] dhi;
        for (int a = 0; a < NA; a++)
        begin
            dlo = 37'(ph_reg[a]) - 37'(lo_c_reg[a]);
            dhi = 37'(ph_reg[a]) - 37'(hi_c_reg[a]);
            if (ph_reg[a] > 36'sh07FFFFFFF)
                imp_next[a] = 32'sh7FFFFFFF;
            else if (ph_reg[a] < -36'sh080000000)
                imp_next[a] = 32'sh80000000;
            else
                imp_next[a] = ph_reg[a][31:0];
            nrm_next[a] = swsb_pkg::NRM_ZERO;
            if (ax_c_reg == swsb_pkg::axis_t'(a))
            begin
                priority if (dlo > -TOL_S && dlo < TOL_S)
                    nrm_next[a] = swsb_pkg::NRM_NEG;
                else if (dhi > -TOL_S && dhi < TOL_S)
                    nrm_next[a] = swsb_pkg::NRM_POS;
                else if (vpos_c_reg[a])
                    nrm_next[a] = swsb_pkg::NRM_NEG;
                else
                    nrm_next[a] = swsb_pkg::NRM_POS;
            end
            if (ax_c_reg == swsb_pkg::AXIS_NONE && a == int'(swsb_pkg::AXIS_Y))
                nrm_next[a] = swsb_pkg::NRM_POS;
            if (!hit_c_reg)
            begin
                imp_next[a] = '0;
                nrm_next[a] = swsb_pkg::NRM_ZERO;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            hit_reg <= hit_c_reg;
            for (int a = 0; a < NA; a++)
            begin
                imp_reg[a] <= imp_next[a];
                nrm_reg[a] <= nrm_next[a];
            end
        end
    end

    assign hit      = hit_reg;
    assign impact_x = imp_reg[0];
    assign impact_y = imp_reg[1];
    assign impact_z = imp_reg[2];
    assign normal_x = nrm_reg[0];
    assign normal_y = nrm_reg[1];
    assign normal_z = nrm_reg[2];

endmodule

`default_nettype wire

// ===== rtl/swept_sphere_box_test_core.sv =====
// ----------------------------------------------------------------------------
// swept_sphere_box_test_core: swept sphere against box, slab method
// Three axis lanes with pipelined dividers feed a merge pipeline.
// ----------------------------------------------------------------------------
// Throughput: one item per cycle while the output does not stall; the per-axis divider pipelines set depth.
// Stages hold independently, so bubbles collapse under output stall.
// Reset clears stage valid bits and the box registers to zero.
// ----------------------------------------------------------------------------
`default_nettype none

module swept_sphere_box_test_core (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [31:0]        cfg_data,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic signed [31:0] start_x,
    input  wire logic signed [31:0] start_y,
    input  wire logic signed [31:0] start_z,
    input  wire logic signed [31:0] end_x,
    input  wire logic signed [31:0] end_y,
    input  wire logic signed [31:0] end_z,
    input  wire logic [30:0]        particle_radius,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic                    hit,
    output logic signed [31:0]      impact_x,
    output logic signed [31:0]      impact_y,
    output logic signed [31:0]      impact_z,
    output logic signed [1:0]       normal_x,
    output logic signed [1:0]       normal_y,
    output logic signed [1:0]       normal_z
);

    localparam int NS = swsb_pkg::NUM_STAGES;
    localparam int NA = swsb_pkg::NUM_AXES;

    logic signed [31:0]  box_min_reg [NA];
    logic signed [31:0]  box_max_reg [NA];
    logic [NS-1:0]       valid_reg;
    logic [NS-1:0]       en;
    logic signed [31:0]  p_start [NA];
    logic signed [31:0]  p_end   [NA];
    swsb_pkg::lane_out_t lane_res [NA];

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int a = 0; a < NA; a++)
            begin
                box_min_reg[a] <= '0;
                box_max_reg[a] <= '0;
            end
        end
        else if (cfg_valid && cfg_ready)
        begin
            priority if (cfg_index <= swsb_pkg::REG_MIN_Z)
                box_min_reg[2'(cfg_index - swsb_pkg::REG_MIN_X)] <= cfg_data;
            else if (cfg_index <= swsb_pkg::REG_MAX_Z)
                box_max_reg[2'(cfg_index - swsb_pkg::REG_MAX_X)] <= cfg_data;
        end
    end

    always_comb
    begin
        en[NS-1] = !valid_reg[NS-1] || !out_stall;
        for (int k = NS - 2; k >= 0; k--)
            en[k] = !valid_reg[k] || en[k+1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
        begin
            if (en[0])
                valid_reg[0] <= in_valid;
            for (int k = 1; k < NS; k++)
            begin
                if (en[k])
                    valid_reg[k] <= valid_reg[k-1];
            end
        end
    end

    assign in_stall  = !en[0];
    assign out_valid = valid_reg[NS-1];

    assign p_start[0] = start_x;
    assign p_start[1] = start_y;
    assign p_start[2] = start_z;
    assign p_end[0]   = end_x;
    assign p_end[1]   = end_y;
    assign p_end[2]   = end_z;

    for (genvar a = 0; a < NA; a++)
    begin : g_lane
        swsb_lane u_lane (
            .clk    (clk),
            .en     (en[swsb_pkg::LANE_STAGES-1:0]),
            .p0     (p_start[a]),
            .pe     (p_end[a]),
            .bmin   (box_min_reg[a]),
            .bmax   (box_max_reg[a]),
            .radius (particle_radius),
            .res    (lane_res[a])
        );
    end

    swsb_merge u_merge (
        .clk      (clk),
        .en       (en[NS-1:swsb_pkg::LANE_STAGES]),
        .lane     (lane_res),
        .hit      (hit),
        .impact_x (impact_x),
        .impact_y (impact_y),
        .impact_z (impact_z),
        .normal_x (normal_x),
        .normal_y (normal_y),
        .normal_z (normal_z)
    );

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !hit |-> impact_x == 0 && impact_y == 0 && impact_z == 0
            && normal_x == 0 && normal_y == 0 && normal_z == 0)
        else $error("miss result carries nonzero fields");

    a_one_normal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && hit |-> $countones({normal_x != 0, normal_y != 0, normal_z != 0}) == 1)
        else $error("hit result without exactly one face normal");

    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (&valid_reg) && out_stall)
        else $error("input stalled while pipeline has a bubble");

    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[NS-2] && !out_stall |=> out_valid)
        else $error("finished item not advanced to output");

endmodule

`default_nettype wire
